>>> design/trl_pkg.sv
package trl_pkg;

  localparam int unsigned TRL_QUEUE_DEPTH = 2;
  localparam int unsigned TRL_MAX_OUT     = 4;

  // held Latin letter waiting for its follower
  typedef enum logic [3:0] {
    PK_NONE,
    PK_Z,
    PK_K,
    PK_T,
    PK_C,
    PK_S,
    PK_SH,
    PK_SHC,
    PK_Y,
    PK_X
  } pend_e;

  typedef struct packed {
    pend_e kind;
    logic  upper;
    logic  c_upper;
    logic  at_start;
  } state_t;

  typedef struct packed {
    logic [TRL_MAX_OUT-1:0][15:0] ch;
    logic [2:0]                   cnt;
  } obuf_t;

  // one queue entry: all output units of one input beat
  typedef struct packed {
    obuf_t b;
    logic  last;
  } bundle_t;

  typedef struct packed {
    state_t s;
    obuf_t  b;
    logic   used;
  } res_t;

  // ASCII code units
  localparam logic [15:0] CH_NUL   = 16'h0000;
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_DOT   = 16'h002E;
  localparam logic [15:0] UC_A     = 16'h0041;
  localparam logic [15:0] UC_C     = 16'h0043;
  localparam logic [15:0] UC_Z     = 16'h005A;
  localparam logic [15:0] LC_A     = 16'h0061;
  localparam logic [15:0] LC_C     = 16'h0063;
  localparam logic [15:0] LC_E     = 16'h0065;
  localparam logic [15:0] LC_H     = 16'h0068;
  localparam logic [15:0] LC_I     = 16'h0069;
  localparam logic [15:0] LC_O     = 16'h006F;
  localparam logic [15:0] LC_S     = 16'h0073;
  localparam logic [15:0] LC_U     = 16'h0075;
  localparam logic [15:0] LC_Z     = 16'h007A;
  localparam logic [15:0] CASE_OFS = 16'h0020;

  // Cyrillic code units, uppercase apart from the _L lowercase entries
  localparam logic [15:0] CY_A    = 16'h0410;
  localparam logic [15:0] CY_BE   = 16'h0411;
  localparam logic [15:0] CY_VE   = 16'h0412;
  localparam logic [15:0] CY_GHE  = 16'h0413;
  localparam logic [15:0] CY_DE   = 16'h0414;
  localparam logic [15:0] CY_IE   = 16'h0415;
  localparam logic [15:0] CY_ZHE  = 16'h0416;
  localparam logic [15:0] CY_ZE   = 16'h0417;
  localparam logic [15:0] CY_I    = 16'h0418;
  localparam logic [15:0] CY_SI   = 16'h0419;
  localparam logic [15:0] CY_KA   = 16'h041A;
  localparam logic [15:0] CY_EL   = 16'h041B;
  localparam logic [15:0] CY_EM   = 16'h041C;
  localparam logic [15:0] CY_EN   = 16'h041D;
  localparam logic [15:0] CY_O    = 16'h041E;
  localparam logic [15:0] CY_PE   = 16'h041F;
  localparam logic [15:0] CY_ER   = 16'h0420;
  localparam logic [15:0] CY_ES   = 16'h0421;
  localparam logic [15:0] CY_TE   = 16'h0422;
  localparam logic [15:0] CY_U    = 16'h0423;
  localparam logic [15:0] CY_EF   = 16'h0424;
  localparam logic [15:0] CY_HA   = 16'h0425;
  localparam logic [15:0] CY_TSE  = 16'h0426;
  localparam logic [15:0] CY_CHE  = 16'h0427;
  localparam logic [15:0] CY_SHA  = 16'h0428;
  localparam logic [15:0] CY_SHCH = 16'h0429;
  localparam logic [15:0] CY_YERU = 16'h042B;
  localparam logic [15:0] CY_SOFT = 16'h042C;
  localparam logic [15:0] CY_EREV = 16'h042D;
  localparam logic [15:0] CY_YU   = 16'h042E;
  localparam logic [15:0] CY_YA   = 16'h042F;
  localparam logic [15:0] CY_YO   = 16'h0401;
  localparam logic [15:0] CY_YO_L = 16'h0451;
  localparam logic [15:0] CY_KA_L = 16'h043A;
  localparam logic [15:0] CY_ES_L = 16'h0441;

  function automatic obuf_t put(obuf_t b, logic [15:0] c);
    obuf_t r;
    r = b;
    if (r.cnt < 3'(TRL_MAX_OUT)) begin
      r.ch[r.cnt[1:0]] = c;
      r.cnt = r.cnt + 3'd1;
    end
    return r;
  endfunction

  function automatic logic [15:0] cy(logic [15:0] code, logic up);
    logic [15:0] r;
    if (up) r = code;
    else if (code == CY_YO) r = CY_YO_L;
    else r = code + CASE_OFS;
    return r;
  endfunction

  function automatic logic [15:0] fold(logic [15:0] c);
    return (c >= UC_A && c <= UC_Z) ? c + CASE_OFS : c;
  endfunction

  // complete the held letter against follower f
  function automatic res_t resolve(state_t s, obuf_t b, logic [15:0] f);
    res_t        r;
    logic [15:0] fl;
    logic        up;
    fl = fold(f);
    up = s.upper;
    r.s = s;
    r.s.kind = PK_NONE;
    r.s.upper = 1'b0;
    r.b = b;
    r.used = 1'b0;
    case (s.kind)
      PK_Z: begin
        r.used = (fl == LC_H);
        r.b = put(r.b, cy(r.used ? CY_ZHE : CY_ZE, up));
      end
      PK_K: begin
        r.used = (fl == LC_H);
        r.b = put(r.b, cy(r.used ? CY_HA : CY_KA, up));
      end
      PK_C: begin
        r.used = (fl == LC_H);
        r.b = put(r.b, cy(r.used ? CY_CHE : CY_KA, up));
      end
      PK_T: begin
        r.used = (fl == LC_S);
        r.b = put(r.b, cy(r.used ? CY_TSE : CY_TE, up));
      end
      PK_S: begin
        if (fl == LC_H) begin
          r.s.kind = PK_SH;
          r.s.upper = up;
          r.used = 1'b1;
        end else begin
          r.b = put(r.b, cy(CY_ES, up));
        end
      end
      PK_SH: begin
        if (fl == LC_C) begin
          r.s.kind = PK_SHC;
          r.s.upper = up;
          r.s.c_upper = (f == UC_C);
          r.used = 1'b1;
        end else begin
          r.b = put(r.b, cy(CY_SHA, up));
        end
      end
      PK_SHC: begin
        if (fl == LC_H) begin
          r.b = put(r.b, cy(CY_SHCH, up));
          r.used = 1'b1;
        end else begin
          // broken shch: Sha then K in the case of the c
          r.b = put(r.b, cy(CY_SHA, up));
          r.b = put(r.b, cy(CY_KA, s.c_upper));
        end
      end
      PK_Y: begin
        if (fl == LC_E) begin
          r.b = put(r.b, cy(CY_IE, up));
          r.used = 1'b1;
        end else if (fl == LC_O) begin
          r.b = put(r.b, cy(CY_YO, up));
          r.used = 1'b1;
        end else if (fl == LC_U) begin
          r.b = put(r.b, cy(CY_YU, up));
          r.used = 1'b1;
        end else if (fl == LC_A) begin
          r.b = put(r.b, cy(CY_YA, up));
          r.used = 1'b1;
        end else if (fl == LC_I) begin
          r.b = put(r.b, cy(CY_SOFT, up));
        end else if (f == CH_NUL || f == CH_SPACE || f == CH_DOT) begin
          r.b = put(r.b, cy(CY_I, up));
          r.b = put(r.b, cy(CY_SI, up));
        end else begin
          r.b = put(r.b, cy(CY_YERU, up));
        end
      end
      PK_X: begin
        r.b = put(r.b, CY_KA);
        r.b = put(r.b, (f >= LC_A && f <= LC_Z) ? CY_ES_L : CY_ES);
      end
      default: ;
    endcase
    return r;
  endfunction

  // code unit with nothing held
  function automatic res_t fresh(state_t s, obuf_t b, logic [15:0] ch);
    res_t        r;
    logic        up;
    logic [15:0] lc;
    up = (ch >= UC_A && ch <= UC_Z);
    lc = fold(ch);
    r.s = s;
    r.b = b;
    r.used = 1'b1;
    case (lc)
      16'h0061: r.b = put(r.b, cy(CY_A, up));   // a
      16'h0062: r.b = put(r.b, cy(CY_BE, up));  // b
      16'h0076: r.b = put(r.b, cy(CY_VE, up));  // v
      16'h0067: r.b = put(r.b, cy(CY_GHE, up)); // g
      16'h0064: r.b = put(r.b, cy(CY_DE, up));  // d
      16'h0065: r.b = put(r.b, cy(s.at_start ? CY_EREV : CY_IE, up));
      16'h0069: r.b = put(r.b, cy(CY_I, up));   // i
      16'h006C: r.b = put(r.b, cy(CY_EL, up));  // l
      16'h006D: r.b = put(r.b, cy(CY_EM, up));  // m
      16'h006E: r.b = put(r.b, cy(CY_EN, up));  // n
      16'h006F: r.b = put(r.b, cy(CY_O, up));   // o
      16'h0070: r.b = put(r.b, cy(CY_PE, up));  // p
      16'h0072: r.b = put(r.b, cy(CY_ER, up));  // r
      16'h0075: r.b = put(r.b, cy(CY_U, up));   // u
      16'h0066: r.b = put(r.b, cy(CY_EF, up));  // f
      16'h007A: begin r.s.kind = PK_Z; r.s.upper = up; end
      16'h006B: begin r.s.kind = PK_K; r.s.upper = up; end
      16'h0074: begin r.s.kind = PK_T; r.s.upper = up; end
      16'h0063: begin r.s.kind = PK_C; r.s.upper = up; end
      16'h0073: begin r.s.kind = PK_S; r.s.upper = up; end
      16'h0079: begin r.s.kind = PK_Y; r.s.upper = up; end
      16'h0078: begin
        if (up) begin
          r.s.kind = PK_X;
          r.s.upper = 1'b1;
        end else begin
          r.b = put(r.b, CY_KA_L);
          r.b = put(r.b, CY_ES_L);
        end
      end
      default: r.b = put(r.b, ch);
    endcase
    return r;
  endfunction

  // whole step for one input beat
  function automatic res_t step(state_t s, logic [15:0] ch, logic last);
    res_t r;
    r.s = s;
    r.b = '0;
    r.used = 1'b0;
    if (r.s.kind != PK_NONE) r = resolve(r.s, r.b, ch);
    if (!r.used) r = fresh(r.s, r.b, ch);
    if (last) begin
      if (r.s.kind != PK_NONE) r = resolve(r.s, r.b, CH_NUL);
      if (r.s.kind != PK_NONE) r = resolve(r.s, r.b, CH_NUL);
      r.s.at_start = 1'b1;
    end else begin
      r.s.at_start = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> design/trl_in_if.sv
interface trl_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] in_char;
  logic        string_last;

  modport source (output valid, output in_char, output string_last, input ready);
  modport sink (input valid, input in_char, input string_last, output ready);
endinterface

>>> design/trl_out_if.sv
interface trl_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_char;
  logic        run_last;
  logic        string_end;

  modport source (output valid, output out_char, output run_last, output string_end,
                  input ready);
  modport sink (input valid, input out_char, input run_last, input string_end,
                output ready);
endinterface

>>> design/trl_front.sv
module trl_front
  import trl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [15:0] in_char_i,
  input  logic        string_last_i,
  output logic        in_ready_o,
  input  logic        full_i,
  output logic        push_o,
  output bundle_t     bundle_o
);

  state_t state_q, state_d;
  res_t   res;
  logic   accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    res = step(state_q, in_char_i, string_last_i);
    state_d = accept ? res.s : state_q;
  end

  // beats that only park a letter produce no queue entry
  assign push_o        = accept && (res.b.cnt != 3'd0);
  assign bundle_o.b    = res.b;
  assign bundle_o.last = string_last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{kind: PK_NONE, upper: 1'b0, c_upper: 1'b0, at_start: 1'b1};
    end else begin
      state_q <= state_d;
    end
  end

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && string_last_i) |=> (state_q.kind == PK_NONE && state_q.at_start))
    else $error("string end left a letter held");

endmodule

>>> design/trl_fifo.sv
module trl_fifo
  import trl_pkg::*;
#(
  parameter int unsigned Depth = TRL_QUEUE_DEPTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t data_i,
  output logic    full_o,
  input  logic    pop_i,
  output bundle_t data_o,
  output logic    empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bundle_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    else if (pop_i && !push_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count out of range");

endmodule

>>> design/trl_back.sv
module trl_back
  import trl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  bundle_t     bundle_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] out_char_o,
  output logic        run_last_o,
  output logic        string_end_o
);

  logic [1:0]  idx_q, idx_d;
  logic        valid_q, valid_d;
  logic [15:0] char_q;
  logic        run_last_q, string_end_q;
  logic        load, is_last;

  // output register takes a new beat when empty or being drained
  assign load    = !empty_i && (!valid_q || out_ready_i);
  assign is_last = ({1'b0, idx_q} + 3'd1 == bundle_i.b.cnt);
  assign pop_o   = load && is_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      idx_d   = is_last ? 2'd0 : idx_q + 2'd1;
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q       <= bundle_i.b.ch[idx_q];
      run_last_q   <= is_last;
      string_end_q <= is_last && bundle_i.last;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_char_o   = char_q;
  assign run_last_o   = run_last_q;
  assign string_end_o = string_end_q;

  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && string_end_q) |-> run_last_q)
    else $error("string end on a beat that is not last of its run");

  a_idx_in_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> ({1'b0, idx_q} < bundle_i.b.cnt))
    else $error("serializer index past entry count");

endmodule

>>> design/latin_to_cyrillic_translit.sv
// Latin to Cyrillic transliterator, one UTF-16 code unit per input beat.
// The results of an input beat are registered in the entry queue, then in the output register.
// Throughput: one result beat per cycle out of the serializer while the output is ready; an
// input beat yields 0..4 results, and one input is taken per cycle while the queue is not full.
// The front stalls only when the entry queue (QueueDepth entries) is full.
// Reset (async, active low) drops any held letter, marks string start, empties the queue.
module latin_to_cyrillic_translit
  import trl_pkg::*;
#(
  parameter int unsigned QueueDepth = TRL_QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  trl_in_if.sink    in_i,
  trl_out_if.source out_o
);

  bundle_t push_data, head_data;
  logic    push, pop, full, empty;

  trl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_char_i     (in_i.in_char),
    .string_last_i (in_i.string_last),
    .in_ready_o    (in_i.ready),
    .full_i        (full),
    .push_o        (push),
    .bundle_o      (push_data)
  );

  trl_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_data),
    .empty_o (empty)
  );

  trl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .bundle_i     (head_data),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_char_o   (out_o.out_char),
    .run_last_o   (out_o.run_last),
    .string_end_o (out_o.string_end)
  );

endmodule
